[hw/rtl/wildcard_alternatives_match_defines.svh]
// ----------------------------------------------------------------------------
// wildcard_alternatives_match_defines
// assertion macros shared by the wildcard matcher rtl
// ----------------------------------------------------------------------------
`ifndef WILDCARD_ALTERNATIVES_MATCH_DEFINES_SVH
`define WILDCARD_ALTERNATIVES_MATCH_DEFINES_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define WAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define WAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WAM_ASSERT(lbl, prop, msg)
`define WAM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/wam_pkg.sv]
// ----------------------------------------------------------------------------
// wam_pkg
// types and symbol codes shared by the wildcard matcher modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wam_pkg;

  typedef enum logic [1:0] {
    FUNC_CLEAR    = 2'd0,
    FUNC_APPEND   = 2'd1,
    FUNC_TEXT     = 2'd2,
    FUNC_END_TEXT = 2'd3
  } wam_func_e;

  localparam logic [7:0] SYM_ANY   = 8'h2A;
  localparam logic [7:0] SYM_SPLIT = 8'h7C;
  localparam logic [7:0] SYM_ONE   = 8'h3F;

  localparam logic [7:0] LOWER_FIRST = 8'h61;
  localparam logic [7:0] LOWER_LAST  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic clear;
    logic append;
    logic text;
    logic scan_end;
  } wam_ctrl_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } wam_result_t;

endpackage

[hw/rtl/wam_cell.sv]
// ----------------------------------------------------------------------------
// wam_cell
// one pattern position: stored symbol, fill flag and active flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wam_cell #(
  parameter int unsigned SymBits = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wam_pkg::wam_ctrl_t ctrl_i,
  input  logic [SymBits-1:0] sym_i,
  input  logic               fill_prev_i,
  input  logic               carry_i,
  input  logic               step_i,
  output logic               fill_o,
  output logic               carry_o,
  output logic               step_o,
  output logic               accept_o
);
  import wam_pkg::*;

  logic               fill_q, fill_d;
  logic               active_q, active_d;
  logic [SymBits-1:0] sym_q;
  logic               star_q, split_q, one_q;
  logic               wr;
  logic               closed;
  logic               hit;

  assign wr     = ctrl_i.append & fill_prev_i & ~fill_q;
  assign closed = active_q | carry_i;
  assign hit    = fill_q & ~star_q & ~split_q & (one_q | (sym_q == sym_i));

  assign fill_o   = fill_q;
  assign carry_o  = fill_q & (split_q | (closed & star_q));
  assign step_o   = closed & hit;
  assign accept_o = closed & ((fill_prev_i & ~fill_q) | (fill_q & split_q));

  always_comb begin
    fill_d   = fill_q;
    active_d = active_q;
    if (ctrl_i.clear) begin
      fill_d   = 1'b0;
      active_d = 1'b0;
    end else if (ctrl_i.scan_end) begin
      active_d = 1'b0;
    end else if (ctrl_i.text) begin
      active_d = (closed & fill_q & star_q) | step_i;
    end else if (wr) begin
      fill_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= 1'b0;
      active_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      sym_q   <= sym_i;
      star_q  <= (sym_i == SymBits'(SYM_ANY));
      split_q <= (sym_i == SymBits'(SYM_SPLIT));
      one_q   <= (sym_i == SymBits'(SYM_ONE));
    end
  end

endmodule

[hw/rtl/wam_out_buf.sv]
// ----------------------------------------------------------------------------
// wam_out_buf
// output register with one skid entry for match results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "wildcard_alternatives_match_defines.svh"

module wam_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  wam_pkg::wam_result_t result_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output wam_pkg::wam_result_t result_o
);
  import wam_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  wam_result_t out_q, out_d;
  wam_result_t skid_q, skid_d;
  logic        out_free;

  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = result_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = result_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  `WAM_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid entry without output entry")
  `WAM_ASSERT(a_no_push_full, !(push_i && skid_valid_q), "result pushed into full buffer")
  `WAM_ASSERT(a_skid_fill_on_stall, !$rose(skid_valid_q) || $past(out_valid_q && out_stall_i),
              "skid filled without a stalled output")

endmodule

[hw/rtl/wildcard_alternatives_match.sv]
// ----------------------------------------------------------------------------
// wildcard_alternatives_match
// unanchored wildcard matcher with star, question mark and alternation
// ----------------------------------------------------------------------------
//  channel  | handshake                     | payload
//  ---------+-------------------------------+------------------------------
//  in       | in_valid_i / in_stall_o       | func_i, symbol_i
//  out      | out_valid_o / out_stall_i     | matched_o, pattern_overflow_o
//
//  one input transfer per cycle while in_stall_o is low; every item is done in the cycle it is taken
//  the row of MAX_PATTERN cells updates all active positions in that cycle
//  an end of text result is registered in the output register, or in the skid entry if the output is stalled
//  in_stall_o rises only while a second result waits behind a stalled output
//  reset empties the pattern and clears all flags; no clearing pass is needed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "wildcard_alternatives_match_defines.svh"

module wildcard_alternatives_match #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             func_i,
  input  logic [SYMBOL_BITS-1:0] symbol_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   matched_o,
  output logic                   pattern_overflow_o
);
  import wam_pkg::*;

  logic                   in_fire;
  wam_func_e              func;
  wam_ctrl_t              ctrl;
  logic [SYMBOL_BITS-1:0] folded;
  logic                   buf_full;

  logic [MAX_PATTERN:0]   fill_chain;
  logic [MAX_PATTERN:0]   carry_chain;
  logic [MAX_PATTERN:0]   step_chain;
  logic [MAX_PATTERN:0]   accept_vec;

  logic        active_tail_q, active_tail_d;
  logic        match_seen_q, match_seen_d;
  logic        overflow_q, overflow_d;
  logic        acc;
  wam_result_t result;
  wam_result_t result_out;

  assign in_stall_o = buf_full;
  assign in_fire    = in_valid_i & ~buf_full;
  assign func       = wam_func_e'(func_i);

  always_comb begin
    ctrl = '0;
    case (func)
      FUNC_CLEAR:    ctrl.clear    = in_fire;
      FUNC_APPEND:   ctrl.append   = in_fire;
      FUNC_TEXT:     ctrl.text     = in_fire;
      FUNC_END_TEXT: ctrl.scan_end = in_fire;
      default:       ctrl          = '0;
    endcase
  end

  always_comb begin
    folded = symbol_i;
    if (symbol_i >= SYMBOL_BITS'(LOWER_FIRST) && symbol_i <= SYMBOL_BITS'(LOWER_LAST)) begin
      folded = symbol_i - SYMBOL_BITS'(CASE_OFFSET);
    end
  end

  assign fill_chain[0]  = 1'b1;
  assign carry_chain[0] = 1'b1;
  assign step_chain[0]  = 1'b0;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    wam_cell #(
      .SymBits(SYMBOL_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .sym_i       (folded),
      .fill_prev_i (fill_chain[i]),
      .carry_i     (carry_chain[i]),
      .step_i      (step_chain[i]),
      .fill_o      (fill_chain[i+1]),
      .carry_o     (carry_chain[i+1]),
      .step_o      (step_chain[i+1]),
      .accept_o    (accept_vec[i])
    );
  end

  // end position after the last cell
  assign accept_vec[MAX_PATTERN] = (active_tail_q | carry_chain[MAX_PATTERN])
                                 & fill_chain[MAX_PATTERN];
  assign acc = |accept_vec;

  always_comb begin
    active_tail_d = active_tail_q;
    match_seen_d  = match_seen_q;
    overflow_d    = overflow_q;
    if (ctrl.clear) begin
      active_tail_d = 1'b0;
      match_seen_d  = 1'b0;
      overflow_d    = 1'b0;
    end else if (ctrl.scan_end) begin
      active_tail_d = 1'b0;
      match_seen_d  = 1'b0;
    end else if (ctrl.text) begin
      active_tail_d = step_chain[MAX_PATTERN];
      match_seen_d  = match_seen_q | acc;
    end else if (ctrl.append && fill_chain[MAX_PATTERN]) begin
      overflow_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_tail_q <= 1'b0;
      match_seen_q  <= 1'b0;
      overflow_q    <= 1'b0;
    end else begin
      active_tail_q <= active_tail_d;
      match_seen_q  <= match_seen_d;
      overflow_q    <= overflow_d;
    end
  end

  assign result.matched  = match_seen_q | acc;
  assign result.overflow = overflow_q;

  wam_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (ctrl.scan_end),
    .result_i    (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_out)
  );

  assign matched_o          = result_out.matched;
  assign pattern_overflow_o = result_out.overflow;

  `WAM_ASSERT_NEXT(a_end_resets_scan, ctrl.scan_end, !match_seen_q && !active_tail_q,
                   "scan state kept after end of text")
  `WAM_ASSERT_NEXT(a_clear_empties, ctrl.clear,
                   fill_chain[MAX_PATTERN:1] == '0 && !overflow_q, "pattern not emptied by clear")
  `WAM_ASSERT(a_fill_contiguous,
              (fill_chain[MAX_PATTERN:1] & (fill_chain[MAX_PATTERN:1] + MAX_PATTERN'(1))) == '0,
              "pattern cells not filled from the front")

endmodule

[tb/wildcard_alternatives_match_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_alternatives_match_checker
// watches the input and result channels of the wildcard matcher, keeps its
// own copy of the pattern and of the active positions, predicts the verdict
// of every end of text and compares it field by field with what comes out
// ----------------------------------------------------------------------------

module wildcard_alternatives_match_checker
  import wam_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] func_i,
  input  logic [7:0] symbol_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       matched_i,
  input  logic       pattern_overflow_i,
  output int         owed_o,
  output int         fail_count_o
);

  logic [7:0]           pat_sym [MAX_PATTERN];
  int                   pat_len;
  logic [MAX_PATTERN:0] live_pos;
  logic                 hit_seen;
  logic                 dropped_seen;
  wam_result_t          verdicts_due [$];
  wam_result_t          oldest;
  int                   fails;

  function automatic logic [7:0] upper_case(input logic [7:0] s);
    if (s >= LOWER_FIRST && s <= LOWER_LAST) begin
      return s - CASE_OFFSET;
    end
    return s;
  endfunction

  // add every alternative start, let stars take empty runs, report an end reached
  function automatic logic seed_alternatives(input  logic [MAX_PATTERN:0] set_in,
                                             output logic [MAX_PATTERN:0] set_out);
    logic reached;
    reached = 1'b0;
    set_out = set_in;
    set_out[0] = 1'b1;
    for (int i = 0; i < pat_len; i++) begin
      if (pat_sym[i] == SYM_SPLIT) begin
        set_out[i+1] = 1'b1;
      end
    end
    for (int i = 0; i < pat_len; i++) begin
      if (set_out[i] && pat_sym[i] == SYM_ANY) begin
        set_out[i+1] = 1'b1;
      end
    end
    for (int i = 0; i <= pat_len; i++) begin
      if (set_out[i]) begin
        if (i == pat_len) begin
          reached = 1'b1;
        end else if (pat_sym[i] == SYM_SPLIT) begin
          reached = 1'b1;
        end
      end
    end
    return reached;
  endfunction

  task automatic take_item(input wam_func_e f, input logic [7:0] raw);
    logic [7:0]           s;
    logic [MAX_PATTERN:0] cur;
    logic [MAX_PATTERN:0] nxt;
    wam_result_t          verdict;
    s = upper_case(raw);
    case (f)
      FUNC_CLEAR: begin
        pat_len      = 0;
        dropped_seen = 1'b0;
        live_pos     = '0;
        hit_seen     = 1'b0;
      end
      FUNC_APPEND: begin
        if (pat_len < MAX_PATTERN) begin
          pat_sym[pat_len] = s;
          pat_len++;
        end else begin
          dropped_seen = 1'b1;
        end
      end
      default: begin
        if (seed_alternatives(live_pos, cur)) begin
          hit_seen = 1'b1;
        end
        if (f == FUNC_END_TEXT) begin
          verdict.matched  = hit_seen;
          verdict.overflow = dropped_seen;
          verdicts_due.push_back(verdict);
          live_pos = '0;
          hit_seen = 1'b0;
        end else begin
          nxt = '0;
          for (int i = 0; i < pat_len; i++) begin
            if (cur[i]) begin
              if (pat_sym[i] == SYM_ANY) begin
                nxt[i] = 1'b1;
              end else if (pat_sym[i] != SYM_SPLIT &&
                           (pat_sym[i] == SYM_ONE || pat_sym[i] == s)) begin
                nxt[i+1] = 1'b1;
              end
            end
          end
          live_pos = nxt;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len      = 0;
      live_pos     = '0;
      hit_seen     = 1'b0;
      dropped_seen = 1'b0;
      fails        = 0;
      verdicts_due.delete();
      owed_o       <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: result transfer with none expected, actual matched %0b overflow %0b",
                   $time, matched_i, pattern_overflow_i);
          fails++;
        end else begin
          oldest = verdicts_due.pop_front();
          if (matched_i !== oldest.matched) begin
            $display("%0t: matched expected %0b actual %0b", $time, oldest.matched, matched_i);
            fails++;
          end
          if (pattern_overflow_i !== oldest.overflow) begin
            $display("%0t: pattern_overflow expected %0b actual %0b",
                     $time, oldest.overflow, pattern_overflow_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        take_item(wam_func_e'(func_i), symbol_i);
      end
      owed_o       <= verdicts_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

[tb/wildcard_alternatives_match_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_alternatives_match_tb
// drives patterns and texts into the wildcard matcher with random gaps and
// output stalls, a short directed opening then random pattern/text runs, and
// gives the verdict from the failure count and the owed count of the checker
// ----------------------------------------------------------------------------

module wildcard_alternatives_match_tb;
  import wam_pkg::*;

  localparam int MAX_PATTERN_FULL = 32;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] func_i;
  logic [7:0] symbol_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       matched_o;
  logic       pattern_overflow_o;

  int owed;
  int fail_count;
  int tx_gap_max;
  int rx_gap_max;
  int rx_hold_cycles;
  int items_sent;
  int drain_cycles;

  wildcard_alternatives_match dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .func_i             (func_i),
    .symbol_i           (symbol_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .matched_o          (matched_o),
    .pattern_overflow_o (pattern_overflow_o)
  );

  wildcard_alternatives_match_checker verdict_watch (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .func_i             (func_i),
    .symbol_i           (symbol_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .matched_i          (matched_o),
    .pattern_overflow_i (pattern_overflow_o),
    .owed_o             (owed),
    .fail_count_o       (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("wildcard_alternatives_match: mismatch");
    $finish;
  end

  task automatic send_item(input wam_func_e f, input logic [7:0] s);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    symbol_i   <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic load_pattern(input string p);
    for (int i = 0; i < p.len(); i++) send_item(FUNC_APPEND, p[i]);
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++) send_item(FUNC_TEXT, t[i]);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] mixed_case_letter();
    logic [7:0] c;
    c = 8'h41 + 8'($urandom_range(0, 2));
    if ($urandom_range(0, 1) == 1) begin
      c = c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic [7:0] pattern_symbol();
    case ($urandom_range(0, 9))
      0, 1:    return SYM_ANY;
      2:       return SYM_ONE;
      3:       return SYM_SPLIT;
      8, 9:    return 8'($urandom_range(0, 255));
      default: return mixed_case_letter();
    endcase
  endfunction

  function automatic logic [7:0] text_symbol();
    if ($urandom_range(0, 9) < 8) begin
      return mixed_case_letter();
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_sequence(input int forced_len);
    int pat_size;
    int texts;
    int text_size;
    if (forced_len >= 0 || $urandom_range(0, 9) < 7) begin
      if (forced_len >= 0 || $urandom_range(0, 4) != 0) begin
        send_item(FUNC_CLEAR, 8'($urandom_range(0, 255)));
      end
      if (forced_len >= 0) begin
        pat_size = forced_len;
      end else if ($urandom_range(0, 11) == 0) begin
        pat_size = $urandom_range(30, 36);
      end else begin
        pat_size = $urandom_range(0, 8);
      end
      repeat (pat_size) send_item(FUNC_APPEND, pattern_symbol());
      texts = $urandom_range(1, 3);
      repeat (texts) begin
        text_size = $urandom_range(0, 10);
        repeat (text_size) send_item(FUNC_TEXT, text_symbol());
        send_item(FUNC_END_TEXT, 8'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send_item(wam_func_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic run_random(input int target);
    while (items_sent < target) send_sequence(-1);
  endtask

  // result side
  initial begin
    int stall_len;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall_len      = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall_len = $urandom_range(0, rx_gap_max);
      end
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    func_i         = FUNC_CLEAR;
    symbol_i       = 8'h00;
    out_stall_i    = 1'b0;
    tx_gap_max     = 0;
    rx_gap_max     = 0;
    rx_hold_cycles = 0;
    items_sent     = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pattern, empty text
    send_item(FUNC_END_TEXT, 8'hFF);
    // question mark and case folding in pattern and text
    load_pattern("a?z");
    send_text("QAbZ");
    send_item(FUNC_END_TEXT, 8'h00);
    send_item(FUNC_END_TEXT, 8'h00);
    // trailing empty alternative
    send_item(FUNC_APPEND, SYM_SPLIT);
    send_item(FUNC_END_TEXT, 8'h00);
    // extreme symbol values around a star
    send_item(FUNC_CLEAR, 8'hFF);
    send_item(FUNC_APPEND, 8'hFF);
    send_item(FUNC_APPEND, SYM_ANY);
    send_item(FUNC_APPEND, 8'h00);
    send_item(FUNC_TEXT, 8'hFF);
    send_item(FUNC_TEXT, 8'h7B);
    send_item(FUNC_TEXT, 8'h00);
    send_item(FUNC_END_TEXT, 8'h00);
    // clear abandons a text in progress
    send_item(FUNC_TEXT, 8'h78);
    send_item(FUNC_CLEAR, 8'h00);
    send_item(FUNC_END_TEXT, 8'h00);
    // star alone on an empty text
    send_item(FUNC_APPEND, SYM_ANY);
    send_item(FUNC_END_TEXT, 8'h00);

    // pattern exactly full, then past capacity
    send_sequence(MAX_PATTERN_FULL);
    send_sequence(MAX_PATTERN_FULL + 3);
    run_random(200);

    tx_gap_max = 6;
    rx_gap_max = 6;
    run_random(400);

    // long output hold while the input keeps offering ends of text
    wait_drained();
    tx_gap_max     = 0;
    rx_hold_cycles = 80;
    load_pattern("b|*");
    repeat (8) begin
      send_text("aB");
      send_item(FUNC_END_TEXT, 8'h00);
    end

    rx_gap_max = 6;
    run_random(600);
    wait_drained();

    tx_gap_max = 6;
    rx_gap_max = 0;
    run_random(800);

    in_valid_i <= 1'b0;
    drain_cycles = 0;
    @(posedge clk_i);
    while (owed != 0 && drain_cycles < 5000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && owed == 0) begin
      $display("wildcard_alternatives_match: match");
    end else begin
      $display("wildcard_alternatives_match: mismatch");
    end
    $finish;
  end

endmodule
